@@ sv/ohi_pkg.sv @@
// ----------------------------------------------------------------------------
// ohi_pkg
// shared widths, default table size and command, status and mode codes for
// the open addressing hash insert core
// ----------------------------------------------------------------------------
package ohi_pkg;

  localparam int TABLE_SIZE_DEF = 16;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int MODE_W   = 2;
  localparam int STEP_W   = 4;
  localparam int STEP_MAX = 8;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP3  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

endpackage

@@ sv/ohi_if.sv @@
// ----------------------------------------------------------------------------
// ohi channel interfaces
// valid/ready channels for commands, results and the probe mode register
// ----------------------------------------------------------------------------
interface ohi_in_if import ohi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] new_value;

  modport source (output valid, output command, output key, output new_value,
                  input ready);
  modport sink   (input valid, input command, input key, input new_value,
                  output ready);
endinterface

interface ohi_out_if import ohi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  replaced_count;

  modport source (output valid, output status, output slot, output replaced_count,
                  input ready);
  modport sink   (input valid, input status, input slot, input replaced_count,
                  output ready);
endinterface

interface ohi_cfg_if import ohi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] probe_mode;

  modport source (output valid, output probe_mode, input ready);
  modport sink   (input valid, input probe_mode, output ready);
endinterface

@@ sv/ohi_mod_unit.sv @@
// ----------------------------------------------------------------------------
// ohi_mod_unit
// remainder of a key by the table size, eight key bits per cycle through a
// short chain of compare and subtract steps against the constant table size
// ----------------------------------------------------------------------------
module ohi_mod_unit import ohi_pkg::*; #(
  parameter int TableSize = TABLE_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [KEY_W-1:0]             dividend_i,
  output logic                         done_o,
  output logic [$clog2(TableSize)-1:0] rem_o
);

  localparam int IdxW   = $clog2(TableSize);
  localparam int RemW   = IdxW + 1;
  localparam int ChunkW = 8;
  localparam int Chunks = KEY_W / ChunkW;
  localparam int CntW   = $clog2(Chunks);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [KEY_W-1:0] dvd_q;
  logic [RemW-1:0]  r_q;
  logic [RemW-1:0]  r_nxt;

  // the partial remainder stays below the table size, so its top bit is clear
  always_comb begin
    r_nxt = r_q;
    for (int b = 0; b < ChunkW; b++) begin
      r_nxt = {r_nxt[RemW-2:0], dvd_q[KEY_W-1-b]};
      if (r_nxt >= RemW'(TableSize)) begin
        r_nxt = r_nxt - RemW'(TableSize);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Chunks - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      r_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[KEY_W-ChunkW-1:0], {ChunkW{1'b0}}};
      r_q   <= r_nxt;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q[IdxW-1:0];

endmodule

@@ sv/ohi_table.sv @@
// ----------------------------------------------------------------------------
// ohi_table
// slot key store and occupied bits, one write and one registered read per
// cycle; the occupied bits are swept clear after reset
// ----------------------------------------------------------------------------
module ohi_table import ohi_pkg::*; #(
  parameter int TableSize = TABLE_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(TableSize)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(TableSize)-1:0] wr_addr_i,
  input  logic [KEY_W-1:0]             wr_key_i,
  output logic                         rd_used_o,
  output logic [KEY_W-1:0]             rd_key_o,
  output logic                         clearing_o
);

  localparam int IdxW = $clog2(TableSize);

  logic             used_mem [TableSize];
  logic [KEY_W-1:0] key_mem  [TableSize];

  logic            clr_q;
  logic [IdxW-1:0] clr_idx_q;
  logic            rd_used_q;
  logic [KEY_W-1:0] rd_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IdxW'(TableSize - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      used_mem[clr_idx_q] <= 1'b0;
    end else if (wr_en_i) begin
      used_mem[wr_addr_i] <= 1'b1;
    end
    rd_used_q <= used_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    rd_key_q <= key_mem[rd_addr_i];
  end

  assign rd_used_o  = rd_used_q;
  assign rd_key_o   = rd_key_q;
  assign clearing_o = clr_q;

endmodule

@@ sv/open_addressing_hash_insert_core.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_insert_core
// hash table insert with linear, step 3 or double hash probing, and update
// of every stored copy of a key, under a small sequencer
//
//   channel  dir  transfer when       payload
//   in_i     in   valid && ready      command, key, new_value
//   out_o    out  valid && ready      status, slot, replaced_count
//   cfg_i    in   valid && ready      probe_mode
//
// insert: the key runs through the remainder unit (S_MOD), then each probe
//   is a registered table read (S_PRB_RD) and a check (S_PRB_CHK), for
//   up to TableSize probes
// update: one table read and check per slot, over all TableSize slots
// after reset a clearing pass over every slot runs before in_i is ready
// one item at a time; a finished result waits in the output register while
//   the next item is taken
// ----------------------------------------------------------------------------
module open_addressing_hash_insert_core import ohi_pkg::*; #(
  parameter int TableSize = TABLE_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ohi_in_if.sink     in_i,
  ohi_out_if.source  out_o,
  ohi_cfg_if.sink    cfg_i
);

  localparam int IdxW = $clog2(TableSize);
  localparam int SumW = IdxW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PRB_RD,
    S_PRB_CHK,
    S_UPD_RD,
    S_UPD_CHK,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q;
  logic                cmd_q, cmd_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [KEY_W-1:0]    nval_q, nval_d;
  logic [IdxW-1:0]     step_q, step_d;
  logic [IdxW-1:0]     pos_q, pos_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                out_vld_q, out_vld_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  logic                in_xfer;
  logic [STEP_W-1:0]   step_raw;
  logic [IdxW-1:0]     step_tab [STEP_MAX+1];
  logic [SumW-1:0]     pos_sum, pos_wrap;

  logic                mod_start, mod_done;
  logic [IdxW-1:0]     mod_rem;
  logic [IdxW-1:0]     tbl_rd_addr;
  logic                tbl_wr_en;
  logic [KEY_W-1:0]    tbl_wr_key;
  logic                tbl_used, tbl_clearing;
  logic [KEY_W-1:0]    tbl_key;

  for (genvar g = 0; g <= STEP_MAX; g++) begin : g_step_tab
    assign step_tab[g] = IdxW'(g % TableSize);
  end

  ohi_mod_unit #(.TableSize(TableSize)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_i.key),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  ohi_table #(.TableSize(TableSize)) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (tbl_rd_addr),
    .wr_en_i    (tbl_wr_en),
    .wr_addr_i  (tbl_rd_addr),
    .wr_key_i   (tbl_wr_key),
    .rd_used_o  (tbl_used),
    .rd_key_o   (tbl_key),
    .clearing_o (tbl_clearing)
  );

  assign in_i.ready = (state_q == S_IDLE) && !tbl_clearing;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign mod_start  = in_xfer && (in_i.command == CMD_INSERT);
  assign cfg_i.ready = 1'b1;

  assign tbl_rd_addr = (state_q == S_UPD_RD || state_q == S_UPD_CHK) ? idx_q : pos_q;
  assign tbl_wr_key  = (state_q == S_UPD_CHK) ? nval_q : key_q;
  assign tbl_wr_en   = ((state_q == S_PRB_CHK) && !tbl_used) ||
                       ((state_q == S_UPD_CHK) && tbl_used && (tbl_key == key_q));

  always_comb begin
    case (mode_q)
      MODE_STEP3:  step_raw = STEP_W'(3);
      MODE_DOUBLE: step_raw = {1'b0, in_i.key[2:0]} + 1'b1;
      default:     step_raw = STEP_W'(1);
    endcase
  end

  assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
  assign pos_wrap = (pos_sum >= SumW'(TableSize)) ? (pos_sum - SumW'(TableSize)) : pos_sum;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    nval_d       = nval_q;
    step_d       = step_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d   = in_i.command;
          key_d   = in_i.key;
          nval_d  = in_i.new_value;
          step_d  = step_tab[step_raw];
          idx_d   = '0;
          count_d = '0;
          state_d = (in_i.command == CMD_INSERT) ? S_MOD : S_UPD_RD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_d   = mod_rem;
          state_d = S_PRB_RD;
        end
      end
      S_PRB_RD: begin
        state_d = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        if (!tbl_used) begin
          res_status_d = STATUS_INSERTED;
          res_slot_d   = SLOT_W'(pos_q);
          state_d      = S_RESP;
        end else if (idx_q == IdxW'(TableSize - 1)) begin
          res_status_d = STATUS_FULL;
          res_slot_d   = '0;
          state_d      = S_RESP;
        end else begin
          idx_d   = idx_q + 1'b1;
          pos_d   = pos_wrap[IdxW-1:0];
          state_d = S_PRB_RD;
        end
      end
      S_UPD_RD: begin
        state_d = S_UPD_CHK;
      end
      S_UPD_CHK: begin
        if (tbl_wr_en && (count_q != '1)) begin
          count_d = count_q + 1'b1;
        end
        if (idx_q == IdxW'(TableSize - 1)) begin
          res_status_d = STATUS_UPDATED;
          res_slot_d   = '0;
          state_d      = S_RESP;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_UPD_RD;
        end
      end
      S_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_count_d  = (cmd_q == CMD_UPDATE) ? count_q : '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_LINEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        mode_q <= cfg_i.probe_mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    nval_q       <= nval_d;
    step_q       <= step_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    count_q      <= count_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = out_status_q;
  assign out_o.slot           = out_slot_q;
  assign out_o.replaced_count = out_count_q;

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr_en |-> !tbl_clearing)
    else $error("table write during clearing pass");

  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("remainder finished outside hash state");

  a_insert_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_status_q != STATUS_UPDATED)) |-> (out_count_q == '0))
    else $error("insert result with nonzero replaced count");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside response state");

endmodule
